// ===== rtl/cia_pkg.sv =====
// Package for the checked integer ALU: opcodes, status codes, beat types.
// No dependencies.
`default_nettype none
package cia_pkg;
   localparam int unsigned StageCount = 32;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_SHL = 4'd4,
      OP_SHR = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7, OP_XOR = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_ADD_OVF = 3'd1, ST_SUB_OVF = 3'd2, ST_MUL_OVF = 3'd3,
      ST_DIV_OVF = 3'd4, ST_DIV_ZERO = 3'd5, ST_SHIFT = 3'd6
   } status_type;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  status;
   } rsp_type;

   // state handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic        done;     // result already final
      logic [2:0]  status;
      logic [3:0]  cmd;
      logic        neg_q;    // quotient sign
      logic [31:0] acc_lo;   // dividend/quotient or multiplier bits
      logic [32:0] acc_hi;   // remainder or signed partial product high half
      logic [31:0] divisor;  // |b| or multiplicand (signed)
      logic [31:0] value;
   } cell_type;
endpackage
`default_nettype wire

// ===== rtl/cia_front.sv =====
// Front stage: decode, add/sub/shift/logic ops, operand setup for mul/div cells.
// Depends on cia_pkg.
`default_nettype none
module cia_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire cia_pkg::req_type in_req,
   output cia_pkg::cell_type     out_cell
);
   cia_pkg::cell_type cell_in, cell_ff;
   logic [32:0] sum_w, dif_w;
   logic [31:0] a, b, abs_a, abs_b, shl_w;
   logic [4:0]  sh;
   logic        b_hi, lost;

   always_comb begin
      a = in_req.operand_a;
      b = in_req.operand_b;
      sh = b[4:0];
      b_hi = |b[31:5];
      sum_w = {a[31], a} + {b[31], b};
      dif_w = {a[31], a} - {b[31], b};
      abs_a = a[31] ? (~a + 32'd1) : a;
      abs_b = b[31] ? (~b + 32'd1) : b;
      shl_w = a << sh;
      lost = (shl_w >> sh) != a;
      cell_in = '0;
      cell_in.valid = in_valid;
      cell_in.cmd = in_req.cmd;
      cell_in.done = 1'b1;
      cell_in.status = cia_pkg::ST_OK;
      unique case (in_req.cmd)
         cia_pkg::OP_ADD: begin
            if (sum_w[32] != sum_w[31]) cell_in.status = cia_pkg::ST_ADD_OVF;
            else cell_in.value = sum_w[31:0];
         end
         cia_pkg::OP_SUB: begin
            if (dif_w[32] != dif_w[31]) cell_in.status = cia_pkg::ST_SUB_OVF;
            else cell_in.value = dif_w[31:0];
         end
         cia_pkg::OP_MUL: begin
            cell_in.done = 1'b0;
            cell_in.acc_lo = b;
            cell_in.divisor = a;
         end
         cia_pkg::OP_DIV: begin
            if (b == '0) cell_in.status = cia_pkg::ST_DIV_ZERO;
            else if (b == '1 && a == 32'h8000_0000) cell_in.status = cia_pkg::ST_DIV_OVF;
            else begin
               cell_in.done = 1'b0;
               cell_in.neg_q = a[31] ^ b[31];
               cell_in.acc_lo = abs_a;
               cell_in.divisor = abs_b;
            end
         end
         cia_pkg::OP_SHL: begin
            if (b_hi || lost) cell_in.status = cia_pkg::ST_SHIFT;
            else cell_in.value = shl_w;
         end
         cia_pkg::OP_SHR: begin
            if (b_hi) cell_in.status = cia_pkg::ST_SHIFT;
            else cell_in.value = a >> sh;
         end
         cia_pkg::OP_AND: cell_in.value = a & b;
         cia_pkg::OP_OR:  cell_in.value = a | b;
         cia_pkg::OP_XOR: cell_in.value = a ^ b;
         default: cell_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) cell_ff.valid <= 1'b0;
   end

   assign out_cell = cell_ff;
endmodule
`default_nettype wire

// ===== rtl/cia_cell.sv =====
// One step cell: one bit of the signed multiply or of the restoring divide.
// Depends on cia_pkg.
`default_nettype none
module cia_cell #(
   parameter int unsigned Index = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cia_pkg::cell_type in_cell,
   output cia_pkg::cell_type      out_cell
);
   cia_pkg::cell_type cell_in, cell_ff;
   logic [33:0] psum;
   logic [32:0] mcand, rem_sh, trial, next_hi;
   logic [31:0] q_abs;

   always_comb begin
      cell_in = in_cell;
      mcand = {in_cell.divisor[31], in_cell.divisor};
      psum = '0;
      rem_sh = '0;
      trial = '0;
      next_hi = '0;
      q_abs = '0;
      if (!in_cell.done && in_cell.cmd == cia_pkg::OP_MUL) begin
         // Booth-free signed shift-add; top bit of b has negative weight
         if (in_cell.acc_lo[0]) begin
            if (Index == cia_pkg::StageCount - 1)
               psum = {in_cell.acc_hi[32], in_cell.acc_hi} - {mcand[32], mcand};
            else
               psum = {in_cell.acc_hi[32], in_cell.acc_hi} + {mcand[32], mcand};
         end else psum = {in_cell.acc_hi[32], in_cell.acc_hi};
         next_hi = psum[33:1];
         cell_in.acc_lo = {psum[0], in_cell.acc_lo[31:1]};
         cell_in.acc_hi = next_hi;
         if (Index == cia_pkg::StageCount - 1) begin
            cell_in.done = 1'b1;
            // fits in 32 bits when the high half is the sign of bit 31
            if (next_hi != {33{psum[0]}})
               cell_in.status = cia_pkg::ST_MUL_OVF;
            else cell_in.value = {psum[0], in_cell.acc_lo[31:1]};
         end
      end else if (!in_cell.done && in_cell.cmd == cia_pkg::OP_DIV) begin
         rem_sh = {in_cell.acc_hi[31:0], in_cell.acc_lo[31]};
         trial = rem_sh - {1'b0, in_cell.divisor};
         cell_in.acc_hi = trial[32] ? rem_sh : trial;
         cell_in.acc_lo = {in_cell.acc_lo[30:0], ~trial[32]};
         if (Index == cia_pkg::StageCount - 1) begin
            cell_in.done = 1'b1;
            q_abs = {in_cell.acc_lo[30:0], ~trial[32]};
            cell_in.value = in_cell.neg_q ? (~q_abs + 32'd1) : q_abs;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) cell_ff.valid <= 1'b0;
   end

   assign out_cell = cell_ff;
endmodule
`default_nettype wire

// ===== rtl/checked_integer_alu_top.sv =====
// From accepted start to rsp_strobe, every opcode passes the front register, the 32 cells and the output register.
// Throughput: one beat per cycle; busy is never raised.
// The chain is 32 cells, one multiply or divide bit each; all other ops pass through.
// Reset clears the valid bits only; no other state. Results cannot be stalled.
// Depends on cia_pkg, cia_front, cia_cell.
`default_nettype none
module checked_integer_alu_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cia_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output cia_pkg::rsp_type      rsp_data
);
   cia_pkg::cell_type chain [cia_pkg::StageCount+1];
   cia_pkg::rsp_type  rsp_ff;
   logic              strobe_ff;

   assign busy = 1'b0;

   cia_front u_front (
      .clock(clock), .reset(reset), .in_valid(start), .in_req(req_data),
      .out_cell(chain[0])
   );

   for (genvar i = 0; i < cia_pkg::StageCount; i++) begin : g_cell
      cia_cell #(.Index(i)) u_cell (
         .clock(clock), .reset(reset), .in_cell(chain[i]), .out_cell(chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain[cia_pkg::StageCount].valid;
      end
      rsp_ff.status <= chain[cia_pkg::StageCount].status;
      rsp_ff.value <= (chain[cia_pkg::StageCount].status == cia_pkg::ST_OK) ?
                      chain[cia_pkg::StageCount].value : '0;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != cia_pkg::ST_OK |-> rsp_data.value == '0)
      else $error("error result with nonzero value");
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      chain[cia_pkg::StageCount].valid |-> chain[cia_pkg::StageCount].done)
      else $error("item left chain unfinished");
   a_status_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.status <= cia_pkg::ST_SHIFT)
      else $error("bad status code");
`endif
endmodule
`default_nettype wire
